// ===== rtl/skrt_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted key record table package
// Shared field widths, operation and status codes, and the payload and
// cell control structs.
// ----------------------------------------------------------------------------
package skrt_pkg;

    localparam int OP_W     = 2;
    localparam int KEY_W    = 31;
    localparam int NAME_W_MAX = 64;
    localparam int GRADE_W  = 10;
    localparam int ST_W     = 3;
    localparam int POS_W    = 5;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;
    localparam logic [OP_W-1:0] OP_LIST   = 2'd3;

    localparam logic [ST_W-1:0] ST_DONE     = 3'd0;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd2;
    localparam logic [ST_W-1:0] ST_RECORD   = 3'd3;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]       op;
        logic [KEY_W-1:0]      student_key;
        logic [NAME_W_MAX-1:0] name_tag;
        logic [GRADE_W-1:0]    grade;
    } t_in;

    typedef struct packed {
        logic [ST_W-1:0]       status;
        logic [POS_W-1:0]      position;
        logic [KEY_W-1:0]      found_key;
        logic [NAME_W_MAX-1:0] found_name;
        logic [GRADE_W-1:0]    found_grade;
        logic                  last;
    } t_out;

    typedef struct packed {
        logic [KEY_W-1:0]      key;
        logic [NAME_W_MAX-1:0] name;
        logic [GRADE_W-1:0]    grade;
    } t_rec;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic cmp;        // capture the compare mark
        logic use_ge;     // mark = key >= search key, else slot > new key
        logic ins;        // open a slot and load the new record
        logic del;        // close the gap at the first match
        logic tok_start;  // place the list token on the head cell
        logic tok_shift;  // move the list token one cell on
    } t_cell_ctrl;

endpackage

// ===== rtl/skrt_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted key record table cell
// Holds one record slot. Compares its key with the broadcast key, and on
// insert or delete takes its neighbor's record to open or close a slot.
// ----------------------------------------------------------------------------
module skrt_cell import skrt_pkg::*; #(
    parameter int NAME_W = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctrl       i_ctrl,
    input  logic [KEY_W-1:0] i_key,
    input  t_rec             i_new,
    input  logic             i_head,
    input  t_rec             i_left_rec,
    input  logic             i_left_valid,
    input  logic             i_left_mark_now,
    input  logic             i_left_mark,
    input  logic             i_left_tok,
    input  t_rec             i_right_rec,
    input  logic             i_right_valid,
    output t_rec             o_rec,
    output logic             o_valid,
    output logic             o_mark_now,
    output logic             o_mark,
    output logic             o_sel,
    output logic             o_tok,
    output logic             o_hit
);

    logic               r_valid;
    logic [KEY_W-1:0]   r_key;
    logic [NAME_W-1:0]  r_name;
    logic [GRADE_W-1:0] r_grade;
    logic               r_mark;
    logic               r_tok;

    logic               n_valid;
    t_rec               n_rec;
    logic               w_load;

    // The table is sorted, so the marked cells form a contiguous run and the
    // first marked cell is the boundary.
    assign o_mark_now = i_ctrl.use_ge ? (r_valid && (r_key >= i_key))
                                      : (!r_valid || (r_key > i_key));
    assign o_hit      = o_mark_now && !i_left_mark_now && r_valid && (r_key == i_key);
    assign o_sel      = r_mark && !i_left_mark;
    assign o_mark     = r_mark;
    assign o_tok      = r_tok;
    assign o_valid    = r_valid;
    assign o_rec      = '{key: r_key, name: NAME_W_MAX'(r_name), grade: r_grade};

    always_comb begin
        n_valid = r_valid;
        n_rec   = o_rec;
        w_load  = 1'b0;
        if (i_ctrl.ins) begin
            if (o_sel) begin
                n_valid = 1'b1;
                n_rec   = i_new;
                w_load  = 1'b1;
            end else if (r_mark) begin
                n_valid = i_left_valid;
                n_rec   = i_left_rec;
                w_load  = 1'b1;
            end
        end else if (i_ctrl.del && r_mark) begin
            n_valid = i_right_valid;
            n_rec   = i_right_rec;
            w_load  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_mark  <= 1'b0;
            r_tok   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_ctrl.cmp) begin
                r_mark <= o_mark_now;
            end
            if (i_ctrl.tok_start) begin
                r_tok <= i_head;
            end else if (i_ctrl.tok_shift) begin
                r_tok <= i_left_tok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_key   <= n_rec.key;
            r_name  <= n_rec.name[NAME_W-1:0];
            r_grade <= n_rec.grade;
        end
    end

endmodule

// ===== rtl/sorted_key_record_table.sv =====
// ----------------------------------------------------------------------------
// Sorted key record table
// Insert, delete and search hold the block through the accept state, one
// compare state across the cell chain and one update state, which waits until
// the result register is free; the result is registered as the block returns
// to idle, and no new command is taken before then. List holds the block until
// its last record is issued, one record per cycle while results are taken.
// Reset empties the table at once; record slots need no clearing.
// ----------------------------------------------------------------------------
module sorted_key_record_table import skrt_pkg::*; #(
    parameter int DEPTH      = 16,
    parameter int NAME_BYTES = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int NAME_W = NAME_BYTES * 8;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam logic [NAME_W_MAX-1:0] NAME_MASK = {NAME_W_MAX{1'b1}} >> (NAME_W_MAX - NAME_W);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;
    localparam logic [1:0] S_LIST = 2'd3;

    logic [1:0]       r_state, n_state;
    t_in              r_req;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_hit;
    t_out             r_out, n_out;
    logic             r_out_valid, n_out_valid;

    t_cell_ctrl       w_ctrl;
    t_rec             w_new;
    t_rec             w_rec [DEPTH];
    logic [DEPTH-1:0] w_valid, w_mark_now, w_mark, w_sel, w_tok, w_hit, w_pick;
    t_rec             w_pick_rec;
    logic [IDX_W-1:0] w_pick_idx;
    logic             w_free, w_full, w_list_last;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_free      = !r_out_valid || i_out_ready;
    assign w_full      = (r_count == CNT_W'(DEPTH));
    assign w_list_last = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
    assign w_new       = '{key: r_req.student_key, name: r_req.name_tag, grade: r_req.grade};

    always_comb begin
        w_ctrl           = '0;
        w_ctrl.cmp       = (r_state == S_CMP);
        w_ctrl.use_ge    = (r_req.op != OP_INSERT);
        w_ctrl.ins       = (r_state == S_EXEC) && w_free && (r_req.op == OP_INSERT) && !w_full;
        w_ctrl.del       = (r_state == S_EXEC) && w_free && (r_req.op == OP_DELETE) && r_hit;
        w_ctrl.tok_start = (r_state == S_EXEC) && w_free && (r_req.op == OP_LIST)
                           && (r_count != '0);
        w_ctrl.tok_shift = (r_state == S_LIST) && w_free;
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_rec w_left_rec, w_right_rec;
        logic w_left_valid, w_left_mark_now, w_left_mark, w_left_tok, w_right_valid;

        if (g == 0) begin : g_first
            assign w_left_rec      = '0;
            assign w_left_valid    = 1'b0;
            assign w_left_mark_now = 1'b0;
            assign w_left_mark     = 1'b0;
            assign w_left_tok      = 1'b0;
        end else begin : g_inner_l
            assign w_left_rec      = w_rec[g-1];
            assign w_left_valid    = w_valid[g-1];
            assign w_left_mark_now = w_mark_now[g-1];
            assign w_left_mark     = w_mark[g-1];
            assign w_left_tok      = w_tok[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right_rec   = '0;
            assign w_right_valid = 1'b0;
        end else begin : g_inner_r
            assign w_right_rec   = w_rec[g+1];
            assign w_right_valid = w_valid[g+1];
        end

        skrt_cell #(
            .NAME_W (NAME_W)
        ) u_cell (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_ctrl          (w_ctrl),
            .i_key           (r_req.student_key),
            .i_new           (w_new),
            .i_head          (g == 0),
            .i_left_rec      (w_left_rec),
            .i_left_valid    (w_left_valid),
            .i_left_mark_now (w_left_mark_now),
            .i_left_mark     (w_left_mark),
            .i_left_tok      (w_left_tok),
            .i_right_rec     (w_right_rec),
            .i_right_valid   (w_right_valid),
            .o_rec           (w_rec[g]),
            .o_valid         (w_valid[g]),
            .o_mark_now      (w_mark_now[g]),
            .o_mark          (w_mark[g]),
            .o_sel           (w_sel[g]),
            .o_tok           (w_tok[g]),
            .o_hit           (w_hit[g])
        );
    end

    // The pick vector is one-hot, so an AND-OR gathers the record and index.
    assign w_pick = (r_state == S_LIST) ? w_tok : w_sel;

    always_comb begin
        w_pick_rec = '0;
        w_pick_idx = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_pick_rec = w_pick_rec | (w_pick[i] ? w_rec[i] : '0);
            w_pick_idx = w_pick_idx | (w_pick[i] ? IDX_W'(i) : '0);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (w_free) begin
                    n_out      = '0;
                    n_out.last = 1'b1;
                    n_state    = S_IDLE;
                    unique case (r_req.op)
                        OP_INSERT: begin
                            if (w_full) begin
                                n_out.status = ST_FULL;
                            end else begin
                                n_out.status      = ST_DONE;
                                n_out.position    = POS_W'(w_pick_idx);
                                n_out.found_key   = w_new.key;
                                n_out.found_name  = w_new.name;
                                n_out.found_grade = w_new.grade;
                                n_count           = r_count + CNT_W'(1);
                            end
                            n_out_valid = 1'b1;
                        end
                        OP_DELETE, OP_SEARCH: begin
                            if (r_hit) begin
                                n_out.status      = (r_req.op == OP_DELETE) ? ST_DONE
                                                                            : ST_RECORD;
                                n_out.position    = POS_W'(w_pick_idx);
                                n_out.found_key   = w_pick_rec.key;
                                n_out.found_name  = w_pick_rec.name;
                                n_out.found_grade = w_pick_rec.grade;
                                if (r_req.op == OP_DELETE) begin
                                    n_count = r_count - CNT_W'(1);
                                end
                            end else begin
                                n_out.status = ST_NOTFOUND;
                            end
                            n_out_valid = 1'b1;
                        end
                        OP_LIST: begin
                            if (r_count == '0) begin
                                n_out.status = ST_EMPTY;
                                n_out_valid  = 1'b1;
                            end else begin
                                n_idx   = '0;
                                n_state = S_LIST;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_LIST: begin
                if (w_free) begin
                    n_out.status      = ST_RECORD;
                    n_out.position    = POS_W'(r_idx);
                    n_out.found_key   = w_pick_rec.key;
                    n_out.found_name  = w_pick_rec.name;
                    n_out.found_grade = w_pick_rec.grade;
                    n_out.last        = w_list_last;
                    n_out_valid       = 1'b1;
                    n_idx             = r_idx + IDX_W'(1);
                    if (w_list_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_hit       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (r_state == S_CMP) begin
                r_hit <= |w_hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_idx <= n_idx;
        if (i_in_valid && o_in_ready) begin
            r_req <= '{op:          i_in_data.op,
                       student_key: i_in_data.student_key,
                       name_tag:    i_in_data.name_tag & NAME_MASK,
                       grade:       i_in_data.grade};
        end
    end

endmodule

// ===== verif/sorted_key_record_table_chk.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted key record table checker
// Watches both channels of the table, keeps its own copy of the sorted
// records, predicts the results of every accepted command and compares each
// accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module sorted_key_record_table_chk import skrt_pkg::*; #(
    parameter int DEPTH      = 16,
    parameter int NAME_BYTES = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  t_out i_out_data,
    output int   o_fail_count,
    output int   o_pending
);

    localparam logic [NAME_W_MAX-1:0] NAME_MASK =
        (NAME_BYTES >= 8) ? '1 : ((64'd1 << (NAME_BYTES * 8)) - 64'd1);

    t_rec rec_slot [DEPTH];
    int   rec_count;
    t_out expected_results [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        rec_count    = 0;
    end

    function automatic t_out make_result(input logic [ST_W-1:0] st, input int pos,
                                         input t_rec rec, input logic is_last);
        t_out res;
        res.status      = st;
        res.position    = pos[POS_W-1:0];
        res.found_key   = rec.key;
        res.found_name  = rec.name;
        res.found_grade = rec.grade;
        res.last        = is_last;
        return res;
    endfunction

    // Applies one command to the shadow records and queues what it returns.
    task automatic apply_table_op(input t_in item);
        int   pos;
        int   hit;
        int   i;
        t_rec new_rec;
        case (item.op)
            OP_INSERT: begin
                if (rec_count >= DEPTH) begin
                    expected_results.push_back(make_result(ST_FULL, 0, '0, 1'b1));
                end else begin
                    // A new record goes after every record with an equal key.
                    pos = 0;
                    while (pos < rec_count && rec_slot[pos].key <= item.student_key)
                        pos++;
                    for (i = rec_count; i > pos; i--)
                        rec_slot[i] = rec_slot[i-1];
                    new_rec.key   = item.student_key;
                    new_rec.name  = item.name_tag & NAME_MASK;
                    new_rec.grade = item.grade;
                    rec_slot[pos] = new_rec;
                    rec_count++;
                    expected_results.push_back(make_result(ST_DONE, pos, new_rec, 1'b1));
                end
            end
            OP_DELETE, OP_SEARCH: begin
                hit = -1;
                for (i = rec_count - 1; i >= 0; i--)
                    if (rec_slot[i].key == item.student_key)
                        hit = i;
                if (hit < 0) begin
                    expected_results.push_back(make_result(ST_NOTFOUND, 0, '0, 1'b1));
                end else if (item.op == OP_SEARCH) begin
                    expected_results.push_back(
                        make_result(ST_RECORD, hit, rec_slot[hit], 1'b1));
                end else begin
                    expected_results.push_back(
                        make_result(ST_DONE, hit, rec_slot[hit], 1'b1));
                    for (i = hit; i + 1 < rec_count; i++)
                        rec_slot[i] = rec_slot[i+1];
                    rec_count--;
                end
            end
            OP_LIST: begin
                if (rec_count == 0)
                    expected_results.push_back(make_result(ST_EMPTY, 0, '0, 1'b1));
                for (i = 0; i < rec_count; i++)
                    expected_results.push_back(
                        make_result(ST_RECORD, i, rec_slot[i], i + 1 == rec_count));
            end
        endcase
    endtask

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_out want;
        if (!i_rst_n) begin
            rec_count = 0;
            expected_results.delete();
            o_pending <= 0;
        end else begin
            if (i_in_valid && i_in_ready)
                apply_table_op(i_in_data);
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result transaction: status %0h position %0h key %0h",
                           i_out_data.status, i_out_data.position, i_out_data.found_key);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", 64'(want.status), 64'(i_out_data.status));
                    check_field("position", 64'(want.position), 64'(i_out_data.position));
                    check_field("found_key", 64'(want.found_key),
                                64'(i_out_data.found_key));
                    check_field("found_name", want.found_name, i_out_data.found_name);
                    check_field("found_grade", 64'(want.found_grade),
                                64'(i_out_data.found_grade));
                    check_field("last", 64'(want.last), 64'(i_out_data.last));
                end
            end
            o_pending <= expected_results.size();
        end
    end

endmodule

// ===== verif/sorted_key_record_table_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted key record table testbench
// Drives insert, delete, search and list commands: a directed pass over the
// empty, duplicate-key and full-table cases, then random phases that fill and
// drain the table, with random idling on both channels, one long output
// stall and one full drain. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
module sorted_key_record_table_tb;
    import skrt_pkg::*;

    localparam int DEPTH        = 16;
    localparam int NAME_BYTES   = 8;
    localparam int RANDOM_ITEMS = 350;
    localparam int PHASE_ITEMS  = 40;
    localparam int QUIET_TAIL   = 50;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 20;

    typedef enum int {PHASE_FILL, PHASE_DRAIN, PHASE_MIXED} t_phase;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic i_out_ready = 1'b0;
    t_in  i_in_data   = '0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_data;

    int fail_count;
    int pending;
    int stall_cycles = 0;
    bit gaps_on      = 1'b1;
    bit hold_req     = 1'b0;

    always #10 i_clk = ~i_clk;

    sorted_key_record_table #(
        .DEPTH      (DEPTH),
        .NAME_BYTES (NAME_BYTES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    sorted_key_record_table_chk #(
        .DEPTH      (DEPTH),
        .NAME_BYTES (NAME_BYTES)
    ) u_table_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Ends the run when no transaction moves on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("[sorted_key_record_table] ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Result side: ready in random bursts, plus one long hold on request.
    initial begin
        wait (i_rst_n);
        forever begin
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (gaps_on && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // Small keys collide often, so duplicates and search hits are common.
    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return KEY_W'($urandom);
            default: return KEY_W'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_op(input t_phase phase);
        int roll;
        roll = $urandom_range(0, 99);
        case (phase)
            PHASE_FILL:  return roll < 65 ? OP_INSERT : roll < 80 ? OP_SEARCH :
                                roll < 90 ? OP_DELETE : OP_LIST;
            PHASE_DRAIN: return roll < 15 ? OP_INSERT : roll < 30 ? OP_SEARCH :
                                roll < 85 ? OP_DELETE : OP_LIST;
            default:     return roll < 35 ? OP_INSERT : roll < 60 ? OP_SEARCH :
                                roll < 85 ? OP_DELETE : OP_LIST;
        endcase
    endfunction

    function automatic t_in make_item(input logic [OP_W-1:0] op,
                                      input logic [KEY_W-1:0] key);
        t_in item;
        item.op          = op;
        item.student_key = key;
        item.name_tag    = {$urandom, $urandom};
        item.grade       = GRADE_W'($urandom);
        return item;
    endfunction

    // Holds the command until the block takes it, then maybe idles a while.
    task automatic offer(input t_in item);
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        t_in    item;
        int     n;
        t_phase phase;

        phase = PHASE_MIXED;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table: list, search and delete.
        offer(make_item(OP_LIST, '0));
        offer(make_item(OP_SEARCH, '0));
        offer(make_item(OP_DELETE, '1));
        item = make_item(OP_INSERT, '0);
        item.name_tag = '1;
        item.grade    = '1;
        offer(item);
        item = make_item(OP_INSERT, '1);
        item.name_tag = '0;
        item.grade    = '0;
        offer(item);
        // Equal keys: the second lands after the first, search finds the first.
        offer(make_item(OP_INSERT, KEY_W'(5)));
        offer(make_item(OP_INSERT, KEY_W'(5)));
        offer(make_item(OP_SEARCH, KEY_W'(5)));
        offer(make_item(OP_LIST, '0));
        offer(make_item(OP_DELETE, KEY_W'(5)));
        for (n = 0; n < DEPTH - 3; n++)
            offer(make_item(OP_INSERT, KEY_W'(40 - 3 * n)));
        offer(make_item(OP_INSERT, KEY_W'(7)));
        offer(make_item(OP_LIST, '0));
        offer(make_item(OP_DELETE, '1));
        wait_all_results();

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % PHASE_ITEMS == 0)
                phase = t_phase'($urandom_range(0, 2));
            if (n == 100)
                hold_req = 1'b1;
            if (n == 200)
                wait_all_results();
            if (n == RANDOM_ITEMS - QUIET_TAIL)
                gaps_on = 1'b0;
            offer(make_item(pick_op(phase), pick_key()));
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("[sorted_key_record_table] OK");
        else
            $display("[sorted_key_record_table] ERROR");
        $finish;
    end

endmodule
